### rtl/mmif_pkg.sv
// Package: types and constants for the masked mean inpaint filter.
package mmif_pkg;

    localparam int MAX_WIDTH_D  = 2048;
    localparam int MAX_HEIGHT_D = 4096;
    localparam int MAX_WINDOW_D = 15;

    localparam logic [2:0] CFG_WINDOW = 3'd0;
    localparam logic [2:0] CFG_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_COLOR  = 3'd3;
    localparam logic [2:0] CFG_SKIP   = 3'd4;

    localparam logic [7:0] MASK_FILL = 8'd255;

    typedef struct packed {
        logic       kind;
        logic [7:0] pixel_ch0;
        logic [7:0] pixel_ch1;
        logic [7:0] pixel_ch2;
        logic [7:0] mask_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_ch0;
        logic [7:0] out_ch1;
        logic [7:0] out_ch2;
        logic       was_filled;
        logic       no_source;
        logic       frame_last;
    } out_item_t;

endpackage

### rtl/masked_mean_inpaint_filter.sv
// Masked mean inpaint filter: a fill pixel takes the floor mean of its usable window
// neighbours; one pixel at a time, window read from a line store ring held in one
// synchronous RAM. A pixel that yields no result passes the transfer and the readiness
// check only. A due result whose centre is not a fill pixel also passes the centre read, the
// divide state and the output register. A fill pixel adds a window scan, one RAM read per
// position, then a serial divide (its steps skipped when no neighbour is usable). The single
// RAM port and the serial divide set the rate. A result waiting in the output register
// holds the next result back, not the next transfer in. The RAM is not cleared; results
// that read never-written entries are undefined.
module masked_mean_inpaint_filter #(
    parameter int MAX_WIDTH  = mmif_pkg::MAX_WIDTH_D,
    parameter int MAX_HEIGHT = mmif_pkg::MAX_HEIGHT_D,
    parameter int MAX_WINDOW = mmif_pkg::MAX_WINDOW_D
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mmif_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mmif_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [12:0]         cfg_data
);

    localparam int RING  = MAX_WINDOW + 1;
    localparam int HMAX  = (MAX_WINDOW - 1) / 2;
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int RGW   = $clog2(RING);
    localparam int CLW   = $clog2(MAX_WIDTH);
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int HW    = $clog2(HMAX + 1) + 1;
    localparam int NW    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int SW    = NW + 8;
    localparam int PW    = CW + RW + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_CEN  = 3'd2;
    localparam logic [2:0] S_WIN  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // configuration
    logic [3:0]  win_reg;
    logic [11:0] wid_reg;
    logic [12:0] hgt_reg;
    logic        color_reg, skip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= 4'd3;
            wid_reg   <= 12'd640;
            hgt_reg   <= 13'd480;
            color_reg <= 1'b1;
            skip_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mmif_pkg::CFG_WINDOW: win_reg   <= cfg_data[3:0];
                mmif_pkg::CFG_WIDTH:  wid_reg   <= cfg_data[11:0];
                mmif_pkg::CFG_HEIGHT: hgt_reg   <= cfg_data;
                mmif_pkg::CFG_COLOR:  color_reg <= cfg_data[0];
                mmif_pkg::CFG_SKIP:   skip_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective sizes
    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic [HW-1:0] hh;
    always_comb
    begin
        if (wid_reg == 12'd0) w_eff = CW'(1);
        else if (32'(wid_reg) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
        else w_eff = CW'(wid_reg);
        if (hgt_reg == 13'd0) h_eff = RW'(1);
        else if (32'(hgt_reg) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
        else h_eff = RW'(hgt_reg);
        if (win_reg == 4'd0) hh = '0;
        else if (32'((win_reg - 4'd1) >> 1) > HMAX) hh = HW'(HMAX);
        else hh = HW'((win_reg - 4'd1) >> 1);
    end

    // line store
    logic [25:0]  mem [DEPTH];
    logic         mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [25:0]  mem_wdata, mem_q;
    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        mem_q <= mem[mem_raddr];
    end

    logic [2:0]    state_reg, state_next;
    logic [RW-1:0] in_row_reg, out_row_reg;
    logic [CW-1:0] in_col_reg, out_col_reg;
    logic signed [HW:0] dr_reg, dc_reg;
    logic [7:0]    cen0_reg, cen1_reg, cen2_reg;
    logic          cfill_reg, rvalid_reg, rd_src_reg;
    logic [SW-1:0] sum0_reg, sum1_reg, sum2_reg;
    logic [NW-1:0] cnt_reg;
    logic [4:0]    dstep_reg;
    logic [SW-1:0] rem0_reg, rem1_reg, rem2_reg;
    logic [7:0]    q0_reg, q1_reg, q2_reg;
    mmif_pkg::out_item_t out_reg;
    logic          ov_reg;

    function automatic logic [AW-1:0] ring_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        logic [RGW-1:0] rr;
        rr = RGW'(r % RING);
        return AW'(rr) * AW'(MAX_WIDTH) + AW'(c[CLW-1:0]);
    endfunction

    // window position
    logic signed [RW+1:0] wr_row;
    logic signed [CW+1:0] wr_col;
    logic win_ok, win_last;
    always_comb
    begin
        wr_row = $signed({2'b00, out_row_reg}) + (RW+2)'(dr_reg);
        wr_col = $signed({2'b00, out_col_reg}) + (CW+2)'(dc_reg);
        win_ok = (wr_row >= 0) && (wr_col >= 0)
              && (wr_row < $signed({2'b00, h_eff})) && (wr_col < $signed({2'b00, w_eff}))
              && !(skip_reg ? (dr_reg == 0 || dc_reg == 0) : (dr_reg == 0 && dc_reg == 0));
        win_last = (dr_reg == $signed({1'b0, hh})) && (dc_reg == $signed({1'b0, hh}));
    end

    // readiness
    logic signed [PW-1:0] lag, need;
    logic due, in_done;
    always_comb
    begin
        in_done = in_row_reg >= h_eff;
        lag  = ($signed(PW'(in_row_reg)) - $signed(PW'(out_row_reg))) * $signed(PW'(w_eff))
             + $signed(PW'(in_col_reg)) - $signed(PW'(out_col_reg));
        need = $signed(PW'(hh)) * $signed(PW'(w_eff)) + $signed(PW'(hh));
        due  = in_done || (lag > need);
    end

    // height shrank below the output row: counters restart before the next transfer
    logic frame_wrap;
    assign frame_wrap = out_row_reg >= h_eff;

    assign in_ready = (state_reg == S_IDLE) && !frame_wrap;
    logic acc;
    assign acc = in_valid && in_ready;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ring_addr(in_row_reg, in_col_reg);
        mem_wdata = {in_data.mask_value == 8'd0, in_data.mask_value == mmif_pkg::MASK_FILL,
                     in_data.pixel_ch2, in_data.pixel_ch1, in_data.pixel_ch0};
        if (acc && !in_data.kind && !in_done && 32'(in_col_reg) < MAX_WIDTH) mem_we = 1'b1;
        if (state_reg == S_CHK)
            mem_raddr = ring_addr(out_row_reg, out_col_reg);
        else
            mem_raddr = ring_addr(RW'(wr_row), CW'(wr_col));
    end

    // divide step: restoring, 8 quotient bits
    logic [SW-1:0] t0, t1, t2;
    always_comb
    begin
        t0 = rem0_reg; t1 = rem1_reg; t2 = rem2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            ov_reg      <= 1'b0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready && state_reg != S_OUT) ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (frame_wrap)
                    begin
                        in_row_reg <= '0; in_col_reg <= '0;
                        out_row_reg <= '0; out_col_reg <= '0;
                    end
                    else if (acc)
                    begin
                        if (!in_data.kind && !in_done)
                        begin
                            if (in_col_reg + CW'(1) >= w_eff)
                            begin
                                in_col_reg <= '0;
                                in_row_reg <= in_row_reg + RW'(1);
                            end
                            else in_col_reg <= in_col_reg + CW'(1);
                        end
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (due) state_reg <= S_CEN;
                    else state_reg <= S_IDLE;
                    dr_reg <= -$signed({1'b0, hh});
                    dc_reg <= -$signed({1'b0, hh});
                end
                S_CEN:
                begin
                    // centre data from the read issued in S_CHK
                    cen0_reg  <= mem_q[7:0];
                    cen1_reg  <= mem_q[15:8];
                    cen2_reg  <= mem_q[23:16];
                    cfill_reg <= mem_q[24];
                    sum0_reg <= '0; sum1_reg <= '0; sum2_reg <= '0; cnt_reg <= '0;
                    if (mem_q[24]) state_reg <= S_WIN;
                    else state_reg <= S_DIV;
                    rvalid_reg <= 1'b0;
                    dstep_reg <= 5'd8;
                end
                S_WIN:
                begin
                    // read issued for the current position, data of the previous one summed
                    if (rvalid_reg && mem_q[25])
                    begin
                        sum0_reg <= sum0_reg + SW'(mem_q[7:0]);
                        sum1_reg <= sum1_reg + SW'(mem_q[15:8]);
                        sum2_reg <= sum2_reg + SW'(mem_q[23:16]);
                        cnt_reg  <= cnt_reg + NW'(1);
                    end
                    if (rd_src_reg)
                    begin
                        state_reg  <= S_DIV;
                        dstep_reg  <= 5'd0;
                        rvalid_reg <= 1'b0;
                    end
                    else
                    begin
                        if (win_last) rd_src_reg <= 1'b1;
                        else if (dc_reg == $signed({1'b0, hh}))
                        begin
                            dc_reg <= -$signed({1'b0, hh});
                            dr_reg <= dr_reg + (HW+1)'(1);
                        end
                        else dc_reg <= dc_reg + (HW+1)'(1);
                        rvalid_reg <= win_ok;
                    end
                end
                S_DIV:
                begin
                    if (dstep_reg == 5'd0)
                    begin
                        rem0_reg <= sum0_reg; rem1_reg <= sum1_reg; rem2_reg <= sum2_reg;
                        dstep_reg <= 5'd1;
                    end
                    else if (dstep_reg <= 5'd8 && cnt_reg != '0 && cfill_reg)
                    begin
                        // quotient bit 8-dstep, most significant first
                        if (t0 >= (SW'(cnt_reg) << (5'd8 - dstep_reg)))
                        begin
                            rem0_reg <= t0 - (SW'(cnt_reg) << (5'd8 - dstep_reg));
                            q0_reg <= {q0_reg[6:0], 1'b1};
                        end
                        else q0_reg <= {q0_reg[6:0], 1'b0};
                        if (t1 >= (SW'(cnt_reg) << (5'd8 - dstep_reg)))
                        begin
                            rem1_reg <= t1 - (SW'(cnt_reg) << (5'd8 - dstep_reg));
                            q1_reg <= {q1_reg[6:0], 1'b1};
                        end
                        else q1_reg <= {q1_reg[6:0], 1'b0};
                        if (t2 >= (SW'(cnt_reg) << (5'd8 - dstep_reg)))
                        begin
                            rem2_reg <= t2 - (SW'(cnt_reg) << (5'd8 - dstep_reg));
                            q2_reg <= {q2_reg[6:0], 1'b1};
                        end
                        else q2_reg <= {q2_reg[6:0], 1'b0};
                        if (dstep_reg == 5'd8) state_reg <= S_OUT;
                        dstep_reg <= dstep_reg + 5'd1;
                    end
                    else state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        logic fill_ok;
                        fill_ok = cfill_reg && cnt_reg != '0;
                        out_reg.out_ch0 <= fill_ok ? q0_reg : cen0_reg;
                        out_reg.out_ch1 <= !color_reg ? 8'd0 : (fill_ok ? q1_reg : cen1_reg);
                        out_reg.out_ch2 <= !color_reg ? 8'd0 : (fill_ok ? q2_reg : cen2_reg);
                        out_reg.was_filled <= fill_ok;
                        out_reg.no_source  <= cfill_reg && cnt_reg == '0;
                        out_reg.frame_last <= (out_row_reg == h_eff - RW'(1))
                                           && (out_col_reg == w_eff - CW'(1));
                        ov_reg <= 1'b1;
                        if (out_col_reg + CW'(1) >= w_eff)
                        begin
                            out_col_reg <= '0;
                            if (out_row_reg + RW'(1) >= h_eff)
                            begin
                                out_row_reg <= '0; in_row_reg <= '0; in_col_reg <= '0;
                            end
                            else out_row_reg <= out_row_reg + RW'(1);
                        end
                        else out_col_reg <= out_col_reg + CW'(1);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_CEN) rd_src_reg <= 1'b0;
        end
    end

    assign state_next = state_reg;
    assign out_valid  = ov_reg;
    assign out_data   = out_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_next != S_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_data))
        else $error("result dropped");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.was_filled && out_data.no_source))
        else $error("filled and no source together");

endmodule
